@@ rtl/core/vfcb_pkg.sv @@
// Shared types, widths and codes of the video fade and crossfade blend core.
// No dependencies; every core file refers to it by scoped names.
`default_nettype none

package vfcb_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS          = 8;
   localparam int LEN_BITS             = 16;
   localparam int NUM_BITS             = 24;  // sample times length
   localparam int DIV_STEPS            = 8;   // quotient never exceeds 255
   localparam int FRAME_COUNT_BITS_DEF = 16;

   // Configuration register indexes
   localparam logic [1:0] CSR_MODE         = 2'd0;
   localparam logic [1:0] CSR_FADE_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_TOTAL_FRAMES = 2'd2;

   // Fade modes
   localparam logic [1:0] MODE_FADE_IN   = 2'd0;
   localparam logic [1:0] MODE_FADE_OUT  = 2'd1;
   localparam logic [1:0] MODE_CROSSFADE = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_DONE
   } state_type;

   // Divider control from the sequencer
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/vfcb_div.sv @@
// Iterative restoring divider with round-half-to-even and clamp to 0..255.
// Depends on vfcb_pkg for widths and the divider control struct.
`default_nettype none

module vfcb_div (
   input  wire                                  clock,
   input  wire  vfcb_pkg::div_ctrl_type         ctrl,
   input  wire  [vfcb_pkg::NUM_BITS-1:0]        num,
   input  wire  [vfcb_pkg::LEN_BITS-1:0]        den,
   output logic [vfcb_pkg::SAMPLE_BITS-1:0]     pixel
);

   localparam int NB = vfcb_pkg::NUM_BITS;
   localparam int LB = vfcb_pkg::LEN_BITS;
   localparam int SB = vfcb_pkg::SAMPLE_BITS;

   logic [NB-1:0] rem_ff, rem_in;
   logic [NB-1:0] dsh_ff, dsh_in;
   logic [SB-1:0] quo_ff, quo_in;
   logic [LB-1:0] den_ff, den_in;
   logic          ge;
   logic [LB:0]   rem2;
   logic [LB:0]   den_x;
   logic          round_up;
   logic [SB:0]   quo_r;

   // One trial subtraction per step, divisor aligned to the quotient bit
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      ge     = (rem_ff >= dsh_ff);
      if (ctrl.load) begin
         rem_in = num;
         dsh_in = NB'(den) << (vfcb_pkg::DIV_STEPS - 1);
         quo_in = '0;
         den_in = den;
      end else if (ctrl.step) begin
         rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[SB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // Round half to even on the final remainder, then saturate
   always_comb begin
      rem2     = {rem_ff[LB-1:0], 1'b0};
      den_x    = {1'b0, den_ff};
      round_up = (rem2 > den_x) || ((rem2 == den_x) && quo_ff[0]);
      quo_r    = {1'b0, quo_ff} + (SB+1)'(round_up);
      pixel    = quo_r[SB] ? {SB{1'b1}} : quo_r[SB-1:0];
   end

endmodule

`default_nettype wire

@@ rtl/core/video_fade_crossfade_blend_core.sv @@
// Top level of the video fade and crossfade blend core: registers, frame
// index, weight set-up, shared multiplier and sequencer. Uses vfcb_pkg, vfcb_div.
`default_nettype none

// Each accepted sample is weighted by a per-frame linear factor (fade in, fade
// out, or crossfade of sample_a into sample_b) and the exact quotient by the
// fade length is rounded half to even. Two passes through one shared 8x16
// multiplier build the numerator, then an iterative restoring divider resolves
// one quotient bit per cycle, and the result is registered. req_tready is high
// only while the sequencer is idle; a finished result waits in the output
// register, so a new sample can be taken before the previous one is collected.
// The frame index counts words with req_tlast set, saturates, and clears on
// any write to registers 0 to 2. Write configuration only while no sample is
// in flight.
module video_fade_crossfade_blend_core #(
   parameter int FRAME_COUNT_BITS = vfcb_pkg::FRAME_COUNT_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // Sample input
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] sample_a, [15:8] sample_b
   input  wire         req_tlast,   // frame_end
   // Result output
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tlast,   // frame_end_out
   // Configuration writes
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   localparam int SB = vfcb_pkg::SAMPLE_BITS;
   localparam int LB = vfcb_pkg::LEN_BITS;
   localparam int NB = vfcb_pkg::NUM_BITS;
   localparam int FB = FRAME_COUNT_BITS;
   localparam int WW = ((FB > LB) ? FB : LB) + 2;
   localparam int CB = $clog2(vfcb_pkg::DIV_STEPS);

   vfcb_pkg::state_type    state_ff, state_in;
   vfcb_pkg::div_ctrl_type div_ctrl;

   logic [1:0]    mode_ff, mode_in;
   logic [LB-1:0] len_ff, len_in;
   logic [LB-1:0] tot_ff, tot_in;
   logic [FB-1:0] idx_ff, idx_in;
   logic [CB-1:0] cnt_ff, cnt_in;

   logic [SB-1:0] a1_ff, a2_ff, a1_in, a2_in;
   logic [LB-1:0] w1_ff, w2_ff, w1_in, w2_in;
   logic [LB-1:0] den_ff, den_in;
   logic          last_ff;
   logic [NB-1:0] acc_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] rsp_pix_ff;
   logic          rsp_last_ff;

   logic          accept;
   logic          csr_hit;
   logic          mul_sel_b;
   logic          acc_load;
   logic          cnt_clear;
   logic          cnt_step;
   logic          rsp_load;
   logic [SB-1:0] mul_a;
   logic [LB-1:0] mul_w;
   logic [NB-1:0] prod;
   logic [NB-1:0] num_sum;
   logic [SB-1:0] div_pixel;

   logic signed [WW-1:0] idx_s, len_s, tot_s, start_s, wout_s, k_s;
   logic [LB-1:0]        k16;
   logic [SB-1:0]        samp_a, samp_b;

   assign accept  = req_tvalid && req_tready;
   assign csr_hit = csr_we && ((csr_index == vfcb_pkg::CSR_MODE) ||
                               (csr_index == vfcb_pkg::CSR_FADE_LENGTH) ||
                               (csr_index == vfcb_pkg::CSR_TOTAL_FRAMES));
   assign samp_a  = req_tdata[SB-1:0];
   assign samp_b  = req_tdata[2*SB-1:SB];

   // Hold configuration; advance or clear the frame index
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      tot_in  = tot_ff;
      idx_in  = idx_ff;
      if (csr_we) begin
         case (csr_index)
            vfcb_pkg::CSR_MODE:         mode_in = csr_wdata[1:0];
            vfcb_pkg::CSR_FADE_LENGTH:  len_in  = csr_wdata;
            vfcb_pkg::CSR_TOTAL_FRAMES: tot_in  = csr_wdata;
            default:                    mode_in = mode_ff;
         endcase
      end
      if (csr_hit) begin
         idx_in = '0;
      end else if (accept && req_tlast && (idx_ff != {FB{1'b1}})) begin
         idx_in = idx_ff + FB'(1);
      end
   end

   // Work out multiplier operands and divisor for the accepted word
   always_comb begin
      idx_s   = signed'(WW'(idx_ff));
      len_s   = signed'(WW'(len_ff));
      tot_s   = signed'(WW'(tot_ff));
      start_s = tot_s - len_s;
      wout_s  = tot_s - idx_s;
      k_s     = (idx_s < len_s) ? idx_s : len_s;
      k16     = k_s[LB-1:0];
      a1_in   = samp_a;
      w1_in   = LB'(1);
      a2_in   = '0;
      w2_in   = '0;
      den_in  = LB'(1);
      if (len_ff != '0) begin
         case (mode_ff)
            vfcb_pkg::MODE_FADE_IN: begin
               w1_in  = k16;
               den_in = len_ff;
            end
            vfcb_pkg::MODE_FADE_OUT: begin
               if (idx_s >= start_s) begin
                  w1_in  = (wout_s > 0) ? wout_s[LB-1:0] : '0;
                  den_in = len_ff;
               end
            end
            vfcb_pkg::MODE_CROSSFADE: begin
               w1_in  = len_ff - k16;
               a2_in  = samp_b;
               w2_in  = k16;
               den_in = len_ff;
            end
            default: begin
               den_in = LB'(1);
            end
         endcase
      end
   end

   // Shared multiplier, used once per operand pair
   assign mul_a   = mul_sel_b ? a2_ff : a1_ff;
   assign mul_w   = mul_sel_b ? w2_ff : w1_ff;
   assign prod    = NB'(mul_a) * NB'(mul_w);
   assign num_sum = acc_ff + prod;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfcb_pkg::ST_IDLE:  if (req_tvalid) state_in = vfcb_pkg::ST_MUL_A;
         vfcb_pkg::ST_MUL_A: state_in = vfcb_pkg::ST_MUL_B;
         vfcb_pkg::ST_MUL_B: state_in = vfcb_pkg::ST_DIV;
         vfcb_pkg::ST_DIV: begin
            if (cnt_ff == CB'(vfcb_pkg::DIV_STEPS - 1)) state_in = vfcb_pkg::ST_DONE;
         end
         vfcb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = vfcb_pkg::ST_IDLE;
         end
         default: state_in = vfcb_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      mul_sel_b     = 1'b0;
      acc_load      = 1'b0;
      cnt_clear     = 1'b0;
      cnt_step      = 1'b0;
      rsp_load      = 1'b0;
      div_ctrl.load = 1'b0;
      div_ctrl.step = 1'b0;
      case (state_ff)
         vfcb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         vfcb_pkg::ST_MUL_A: begin
            acc_load = 1'b1;
         end
         vfcb_pkg::ST_MUL_B: begin
            mul_sel_b     = 1'b1;
            div_ctrl.load = 1'b1;
            cnt_clear     = 1'b1;
         end
         vfcb_pkg::ST_DIV: begin
            div_ctrl.step = 1'b1;
            cnt_step      = 1'b1;
         end
         vfcb_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Divider step count
   always_comb begin
      cnt_in = cnt_ff;
      if (cnt_clear) begin
         cnt_in = '0;
      end else if (cnt_step) begin
         cnt_in = cnt_ff + CB'(1);
      end
   end

   // Output register: load a finished word, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfcb_pkg::ST_IDLE;
         mode_ff      <= '0;
         len_ff       <= '0;
         tot_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         tot_ff       <= tot_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a1_ff   <= a1_in;
         w1_ff   <= w1_in;
         a2_ff   <= a2_in;
         w2_ff   <= w2_in;
         den_ff  <= den_in;
         last_ff <= req_tlast;
      end
      if (acc_load) begin
         acc_ff <= prod;
      end
      if (rsp_load) begin
         rsp_pix_ff  <= div_pixel;
         rsp_last_ff <= last_ff;
      end
   end

   vfcb_div u_div (
      .clock (clock),
      .ctrl  (div_ctrl),
      .num   (num_sum),
      .den   (den_ff),
      .pixel (div_pixel)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ dv/video_fade_crossfade_blend_core_tb.sv @@
// Self-checking bench for video_fade_crossfade_blend_core: directed corner words
// and random fade settings, with random idling on both stream sides.
// Depends on vfcb_pkg and the core RTL only.

module video_fade_crossfade_blend_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  MODE_UNUSED = 2'd3;   // no fade, sample passes through
   localparam logic [1:0]  CSR_SPARE   = 2'd3;   // unmapped register index
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct {
      logic [7:0] pixel;
      logic       last;
   } pixel_word_type;

   // Tracks fade settings and frame index; holds expected output words in order
   class fade_scoreboard_type;
      logic [1:0]  mode_sel;
      logic [15:0] fade_len;
      logic [15:0] clip_len;
      logic [15:0] frame_idx;
      pixel_word_type expected_q[$];
      int unsigned faults;

      function new();
         mode_sel  = vfcb_pkg::MODE_FADE_IN;
         fade_len  = '0;
         clip_len  = '0;
         frame_idx = '0;
         faults    = 0;
      endfunction

      // Any write to a mapped register restarts the frame count
      function void apply_write(logic [1:0] index, logic [15:0] value);
         case (index)
            vfcb_pkg::CSR_MODE: begin
               mode_sel  = value[1:0];
               frame_idx = '0;
            end
            vfcb_pkg::CSR_FADE_LENGTH: begin
               fade_len  = value;
               frame_idx = '0;
            end
            vfcb_pkg::CSR_TOTAL_FRAMES: begin
               clip_len  = value;
               frame_idx = '0;
            end
            default: ;
         endcase
      endfunction

      // Exact quotient, rounded half to even, clamped to the sample range
      function logic [7:0] round_to_sample(longint num, longint den);
         longint q;
         longint r;
         if (num <= 0) return 8'd0;
         q = num / den;
         r = num % den;
         if (2 * r > den || (2 * r == den && (q % 2) != 0)) q++;
         if (q > 255) q = 255;
         return q[7:0];
      endfunction

      function logic [7:0] blend(logic [7:0] a, logic [7:0] b);
         longint pa, pb, len, idx, k, clip, start;
         pa    = longint'(a);
         pb    = longint'(b);
         len   = longint'(fade_len);
         idx   = longint'(frame_idx);
         clip  = longint'(clip_len);
         k     = (idx < len) ? idx : len;
         start = clip - len;
         if (len == 0) return a;
         case (mode_sel)
            vfcb_pkg::MODE_FADE_IN:   return round_to_sample(pa * k, len);
            vfcb_pkg::MODE_FADE_OUT: begin
               if (idx < start) return a;
               return round_to_sample(pa * (len - (idx - start)), len);
            end
            vfcb_pkg::MODE_CROSSFADE: return round_to_sample(pa * (len - k) + pb * k, len);
            default:                  return a;
         endcase
      endfunction

      function void note_sample(logic [7:0] a, logic [7:0] b, logic last);
         pixel_word_type w;
         w.pixel = blend(a, b);
         w.last  = last;
         expected_q = {expected_q, w};
         // advance the frame index on end of frame, saturating
         if (last && frame_idx != 16'hFFFF) frame_idx++;
      endfunction

      function void check_word(logic [7:0] pixel, logic last);
         pixel_word_type want;
         if (expected_q.size() == 0) begin
            $error("output word with no sample outstanding: pixel_out %0d", pixel);
            faults++;
            return;
         end
         want = expected_q.pop_front();
         if (want.pixel !== pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, pixel);
            faults++;
         end
         if (want.last !== last) begin
            $error("frame_end_out: expected %0b, got %0b", want.last, last);
            faults++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] sample_a, [15:8] sample_b
   logic        req_tlast  = 1'b0; // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] pixel_out
   logic        rsp_tlast;         // frame_end_out
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   int unsigned sender_idle_pct   = 21;
   int unsigned receiver_idle_pct = 86;
   int unsigned stall_cycles      = 0;

   fade_scoreboard_type board = new();

   video_fade_crossfade_blend_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stall at random according to the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Observe register writes and both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            board.note_sample(req_tdata[7:0], req_tdata[15:8], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tlast);
      end
   end

   // Abort if nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [7:0] pick_sample();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   // Present one word, idling first at random; returns on the accepting edge
   task automatic send_sample(logic [7:0] a, logic [7:0] b, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every expected word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // Leaves csr_we high; the caller lowers it after its last write
   task automatic drive_csr(logic [1:0] index, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all three registers in a random order once the core is idle
   task automatic configure(logic [1:0] mode_sel, logic [15:0] len, logic [15:0] clip);
      int unsigned first;
      bit          backwards;
      logic [1:0]  idx;
      logic [15:0] mode_word;
      int          k;
      wait_drained();
      first     = $urandom_range(2);
      backwards = 1'($urandom_range(1));
      for (k = 0; k < 3; k++) begin
         idx = backwards ? 2'((first + 3 - k) % 3) : 2'((first + k) % 3);
         case (idx)
            vfcb_pkg::CSR_MODE: begin
               mode_word      = 16'($urandom());
               mode_word[1:0] = mode_sel;
               drive_csr(idx, mode_word);
            end
            vfcb_pkg::CSR_FADE_LENGTH: drive_csr(idx, len);
            default:                   drive_csr(idx, clip);
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // One random setting followed by frames of random length and content
   task automatic run_segment(int unsigned n_items);
      int unsigned r, sent, frame_len, j, spare_at;
      int          len, clip;
      logic [1:0]  mode_sel;
      bit          spare;
      logic        last;
      r = $urandom_range(99);
      if (r < 30)      mode_sel = vfcb_pkg::MODE_FADE_IN;
      else if (r < 60) mode_sel = vfcb_pkg::MODE_FADE_OUT;
      else if (r < 92) mode_sel = vfcb_pkg::MODE_CROSSFADE;
      else             mode_sel = MODE_UNUSED;
      r = $urandom_range(99);
      if (r < 10)      len = 0;
      else if (r < 75) len = $urandom_range(12, 1);
      else if (r < 90) len = $urandom_range(65534, 13);
      else             len = 65535;
      r = $urandom_range(99);
      if (r < 55)      clip = len + $urandom_range(12);
      else if (r < 80) clip = $urandom_range(len);
      else if (r < 95) clip = $urandom_range(65535);
      else             clip = 65535;
      if (clip > 65535) clip = 65535;
      configure(mode_sel, len[15:0], clip[15:0]);

      spare    = ($urandom_range(99) < 15);
      spare_at = $urandom_range(n_items - 1);
      sent     = 0;
      while (sent < n_items) begin
         frame_len = ($urandom_range(9) == 0) ? $urandom_range(20, 5) : $urandom_range(4, 1);
         for (j = 0; j < frame_len && sent < n_items; j++) begin
            // unmapped write mid-run: the frame count must carry on
            if (spare && sent == spare_at) begin
               wait_drained();
               drive_csr(CSR_SPARE, 16'($urandom()));
               csr_we <= 1'b0;
            end
            last = (j == frame_len - 1);
            if ($urandom_range(19) == 0) last = 1'($urandom_range(1));
            send_sample(pick_sample(), pick_sample(), last);
            sent++;
         end
      end
   endtask

   task automatic run_random(int unsigned total);
      int unsigned done, n;
      done = 0;
      while (done < total) begin
         n = $urandom_range(80, 20);
         run_segment(n);
         done += n;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // After reset: zero fade length passes samples through
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd0, 8'd255, 1'b0);

      // Fade in over four frames, with a tie at half weight and an unmapped write
      configure(vfcb_pkg::MODE_FADE_IN, 16'd4, 16'd0);
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd1, 8'd0, 1'b0);
      send_sample(8'd255, 8'd0, 1'b1);
      wait_drained();
      drive_csr(CSR_SPARE, 16'hFFFF);
      csr_we <= 1'b0;
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd200, 8'd0, 1'b1);

      // Fade out running past the clip end
      configure(vfcb_pkg::MODE_FADE_OUT, 16'd2, 16'd3);
      send_sample(8'd200, 8'd0, 1'b1);
      send_sample(8'd200, 8'd0, 1'b1);
      send_sample(8'd3, 8'd0, 1'b0);
      send_sample(8'd200, 8'd0, 1'b1);
      send_sample(8'd200, 8'd0, 1'b1);
      send_sample(8'd200, 8'd0, 1'b1);

      // Fade length longer than the clip: fade out starts part way down
      configure(vfcb_pkg::MODE_FADE_OUT, 16'd4, 16'd1);
      send_sample(8'd255, 8'd255, 1'b1);
      send_sample(8'd255, 8'd255, 1'b1);

      // Crossfade, index saturating at the fade length
      configure(vfcb_pkg::MODE_CROSSFADE, 16'd3, 16'd3);
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd0, 8'd255, 1'b1);
      send_sample(8'd255, 8'd255, 1'b1);
      send_sample(8'd10, 8'd200, 1'b1);
      send_sample(8'd10, 8'd200, 1'b0);

      // Unused mode, then crossfade with zero length
      configure(MODE_UNUSED, 16'd5, 16'd9);
      send_sample(8'd77, 8'd200, 1'b1);
      send_sample(8'd255, 8'd0, 1'b0);
      configure(vfcb_pkg::MODE_CROSSFADE, 16'd0, 16'd65535);
      send_sample(8'd13, 8'd250, 1'b1);

      run_random(540);

      sender_idle_pct   = 86;
      receiver_idle_pct = 21;
      run_random(540);

      // No idling on either side
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(540);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.faults == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/vfcb_pkg.sv
rtl/core/vfcb_div.sv
rtl/core/video_fade_crossfade_blend_core.sv
dv/video_fade_crossfade_blend_core_tb.sv
